[sv/bmg_pkg.sv]
// Shared constants, latencies and series divisor tables for the Box-Muller pipeline.
package bmg_pkg;

  localparam int unsigned OutFracBitsDef = 27;

  localparam logic [30:0] Ln2Q31    = 31'd1488522236;
  localparam logic [30:0] HalfPiQ30 = 31'd1686629713;
  localparam logic [30:0] OneQ30    = 31'h4000_0000;

  localparam int unsigned LogSteps  = 28;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned SerSlots  = 6;

  localparam int unsigned LogLat   = LogSteps + 3;
  localparam int unsigned SqrtLat  = SqrtSteps;
  localparam int unsigned SinLat   = 3 + 3 * SerSlots + 1;
  localparam int unsigned SinDelay = LogLat + SqrtLat - SinLat;

  typedef struct packed {
    logic [7:0]  divisor;
    logic [31:0] recip;
  } ser_const_t;

  // Horner slot constants; sine leaves slot 0 as a pass-through
  function automatic ser_const_t ser_const(input int unsigned slot, input logic cos_sel);
    ser_const_t c;
    c = '{divisor: 8'd2, recip: 32'd2147483648};
    if (cos_sel) begin
      case (slot)
        0: c = '{divisor: 8'd132, recip: 32'd32537631};
        1: c = '{divisor: 8'd90,  recip: 32'd47721858};
        2: c = '{divisor: 8'd56,  recip: 32'd76695844};
        3: c = '{divisor: 8'd30,  recip: 32'd143165576};
        4: c = '{divisor: 8'd12,  recip: 32'd357913941};
        default: c = '{divisor: 8'd2, recip: 32'd2147483648};
      endcase
    end else begin
      case (slot)
        1: c = '{divisor: 8'd110, recip: 32'd39045157};
        2: c = '{divisor: 8'd72,  recip: 32'd59652323};
        3: c = '{divisor: 8'd42,  recip: 32'd102261126};
        4: c = '{divisor: 8'd20,  recip: 32'd214748364};
        5: c = '{divisor: 8'd6,   recip: 32'd715827882};
        default: c = '{divisor: 8'd110, recip: 32'd39045157};
      endcase
    end
    return c;
  endfunction

endpackage

[sv/bmg_log.sv]
// Pipelined -2 ln(u0): leading-one normalise, repeated squaring, scale by 2 ln 2.
module bmg_log import bmg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] radius_i,
  output logic        valid_o,
  output logic [33:0] e_o
);

  logic [31:0]         y_q  [0:LogSteps];
  logic [LogSteps-1:0] fr_q [0:LogSteps];
  logic [5:0]          ip_q [0:LogSteps];
  logic                vld_q [0:LogSteps+2];
  logic [33:0]         l2_q;
  logic [33:0]         e_q;

  logic [31:0] m;
  logic [4:0]  top;
  logic [31:0] y0;

  always_comb begin
    m   = (radius_i == 32'd0) ? 32'd1 : radius_i;
    top = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) top = 5'(i);
    end
    y0 = m << (5'd31 - top);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LogSteps + 2; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= LogSteps + 2; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q[0]  <= y0;
      fr_q[0] <= '0;
      ip_q[0] <= 6'd32 - {1'b0, top};
    end
  end

  for (genvar k = 1; k <= LogSteps; k++) begin : g_sq
    logic [63:0] sq;
    assign sq = 64'(y_q[k-1]) * 64'(y_q[k-1]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[k]  <= sq[63] ? sq[63:32] : sq[62:31];
        fr_q[k] <= {fr_q[k-1][LogSteps-2:0], sq[63]};
        ip_q[k] <= ip_q[k-1];
      end
    end
  end

  logic [64:0] ep;
  assign ep = 65'(l2_q) * 65'(Ln2Q31);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l2_q <= {ip_q[LogSteps], 28'd0} - 34'(fr_q[LogSteps]);
      e_q  <= ep[63:30];
    end
  end

  assign valid_o = vld_q[LogSteps+2];
  assign e_o     = e_q;

endmodule

[sv/bmg_sqrt.sv]
// Pipelined bit-by-bit integer square root, one result bit per stage.
module bmg_sqrt import bmg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [61:0] v_i,
  output logic        valid_o,
  output logic [30:0] root_o
);

  logic [63:0] v_q   [0:SqrtSteps];
  logic [63:0] res_q [0:SqrtSteps];
  logic        vld_q [0:SqrtSteps];

  assign v_q[0]   = 64'(v_i);
  assign res_q[0] = '0;
  assign vld_q[0] = valid_i;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_bit
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = res_q[k] + Bit;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_q[k] >= trial) begin
          v_q[k+1]   <= v_q[k] - trial;
          res_q[k+1] <= (res_q[k] >> 1) + Bit;
        end else begin
          v_q[k+1]   <= v_q[k];
          res_q[k+1] <= res_q[k] >> 1;
        end
      end
    end
  end

  assign valid_o = vld_q[SqrtSteps];
  assign root_o  = res_q[SqrtSteps][30:0];

endmodule

[sv/bmg_sin.sv]
// Pipelined |sin(2 pi u1)|: octant reduction and Horner series with constant divides.
module bmg_sin import bmg_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] angle_i,
  output logic [30:0] sin_o,
  output logic        neg_o
);

  logic [30:0] qr;
  logic        sel0;
  logic [29:0] base0;

  always_comb begin
    qr    = angle_i[30] ? (OneQ30 - {1'b0, angle_i[29:0]}) : {1'b0, angle_i[29:0]};
    sel0  = qr > 31'h2000_0000;
    base0 = sel0 ? 30'(OneQ30 - qr) : qr[29:0];
  end

  logic [29:0] base_q;
  logic        sel_r_q, neg_r_q;
  logic [29:0] x1_q;
  logic        sel1_q, neg1_q;
  logic [60:0] xp;

  assign xp = 61'(base_q) * 61'(HalfPiQ30) + 61'h2000_0000;

  logic [29:0] x_s   [0:SerSlots];
  logic [29:0] x2_s  [0:SerSlots];
  logic [30:0] t_s   [0:SerSlots];
  logic        sel_s [0:SerSlots];
  logic        neg_s [0:SerSlots];
  logic [59:0] xx;

  assign xx       = 60'(x1_q) * 60'(x1_q);
  assign t_s[0]   = OneQ30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q   <= base0;
      sel_r_q  <= sel0;
      neg_r_q  <= angle_i[31];
      x1_q     <= xp[59:30];
      sel1_q   <= sel_r_q;
      neg1_q   <= neg_r_q;
      x_s[0]   <= x1_q;
      x2_s[0]  <= xx[59:30];
      sel_s[0] <= sel1_q;
      neg_s[0] <= neg1_q;
    end
  end

  for (genvar s = 0; s < SerSlots; s++) begin : g_slot
    logic [29:0] a_p_q, a_x_q, a_x2_q;
    logic        a_sel_q, a_neg_q;
    logic [29:0] b_p_q, b_qe_q, b_x_q, b_x2_q;
    logic        b_sel_q, b_neg_q;
    logic [60:0] pt;
    logic [61:0] pm;
    logic [37:0] qd, rr;
    logic [29:0] qc;
    ser_const_t  ca, cb;

    assign pt = 61'(x2_s[s]) * 61'(t_s[s]);
    assign ca = ser_const(s, a_sel_q);
    assign cb = ser_const(s, b_sel_q);
    assign pm = 62'(a_p_q) * 62'(ca.recip);
    assign qd = 38'(b_qe_q) * 38'(cb.divisor);
    assign rr = 38'(b_p_q) - qd;
    assign qc = (rr >= 38'(cb.divisor)) ? b_qe_q + 30'd1 : b_qe_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_p_q     <= pt[59:30];
        a_x_q     <= x_s[s];
        a_x2_q    <= x2_s[s];
        a_sel_q   <= sel_s[s];
        a_neg_q   <= neg_s[s];
        b_p_q     <= a_p_q;
        b_qe_q    <= pm[61:32];
        b_x_q     <= a_x_q;
        b_x2_q    <= a_x2_q;
        b_sel_q   <= a_sel_q;
        b_neg_q   <= a_neg_q;
        t_s[s+1]  <= (s == 0 && !b_sel_q) ? OneQ30 : OneQ30 - 31'(qc);
        x_s[s+1]  <= b_x_q;
        x2_s[s+1] <= b_x2_q;
        sel_s[s+1] <= b_sel_q;
        neg_s[s+1] <= b_neg_q;
      end
    end
  end

  logic [60:0] xt;
  logic [30:0] s_q;
  logic        n_q;

  assign xt = 61'(x_s[SerSlots]) * 61'(t_s[SerSlots]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= sel_s[SerSlots] ? t_s[SerSlots] : xt[60:30];
      n_q <= neg_s[SerSlots];
    end
  end

  assign sin_o = s_q;
  assign neg_o = n_q;

endmodule

[sv/box_muller_gaussian.sv]
// Top level: Box-Muller normal sample generator, fully pipelined.
//
//  channel | ports                                          | direction
//  in      | in_valid_i, in_stall_o, uniform_radius_i,      | into block
//          | uniform_angle_i                                |
//  out     | out_valid_o, out_stall_i, gaussian_sample_o    | out of block
//
// One transfer per cycle in, one per cycle out while the output is not stalled; the depth
// comes mostly from the 28 squaring stages of the log and the 32 stages of the square root.
// Reset clears only the valid bits of every stage.
// A stalled output that holds a valid sample freezes the whole pipeline, holding every stage in place.
module box_muller_gaussian import bmg_pkg::*; #(
  parameter int unsigned OUT_FRAC_BITS = OutFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] uniform_radius_i,
  input  logic [31:0] uniform_angle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] gaussian_sample_o
);

  localparam int unsigned Sh = 58 - OUT_FRAC_BITS;

  logic en;
  logic out_valid_q;
  logic [31:0] sample_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  logic        log_vld;
  logic [33:0] e;
  logic        sq_vld;
  logic [30:0] root;
  logic [30:0] sin_v;
  logic        sin_neg;

  bmg_log u_log (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .radius_i (uniform_radius_i),
    .valid_o  (log_vld),
    .e_o      (e)
  );

  bmg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (log_vld),
    .v_i     ({e, 28'd0}),
    .valid_o (sq_vld),
    .root_o  (root)
  );

  bmg_sin u_sin (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (uniform_angle_i),
    .sin_o   (sin_v),
    .neg_o   (sin_neg)
  );

  logic [30:0] sd_q [0:SinDelay-1];
  logic        nd_q [0:SinDelay-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sin_v;
      nd_q[0] <= sin_neg;
      for (int k = 1; k < SinDelay; k++) begin
        sd_q[k] <= sd_q[k-1];
        nd_q[k] <= nd_q[k-1];
      end
    end
  end

  logic [61:0] prod_q;
  logic        pneg_q;
  logic        pvld_q;
  logic [61:0] prod;
  logic [61:0] rnd;
  logic [61:0] mag;
  logic [31:0] res;

  assign prod = 62'(root) * 62'(sd_q[SinDelay-1]);

  always_comb begin
    rnd = prod_q + (62'd1 << (Sh - 1));
    mag = rnd >> Sh;
    res = (mag > 62'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    if (pneg_q) res = 32'd0 - res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      pvld_q      <= sq_vld;
      out_valid_q <= pvld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= prod;
      pneg_q   <= nd_q[SinDelay-1];
      sample_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign gaussian_sample_o = sample_q;

endmodule

[sim/box_muller_gaussian_test.sv]
// Testbench for box_muller_gaussian: random and directed transfers, bit-exact predictor.
module box_muller_gaussian_test;
  import bmg_pkg::*;

  localparam int unsigned FracBits = OutFracBitsDef;
  localparam int unsigned Latency  = 65;
  localparam int unsigned Watchdog = 20000;

  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] angle;
  } uniform_pair_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] uniform_radius_i;
  logic [31:0] uniform_angle_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic signed [31:0] gaussian_sample_o;

  uniform_pair_t pending_q[$];
  logic [31:0]   sample_q[$];
  int unsigned   n_errors;
  int unsigned   idle_cycles;
  int unsigned   burst_left;
  int unsigned   gap_left;
  int unsigned   stall_mode;
  int unsigned   hold_off;
  bit            drain_req;
  bit            hold_req;
  bit            stim_done;

  box_muller_gaussian dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .uniform_radius_i, .uniform_angle_i,
    .out_valid_o, .out_stall_i, .gaussian_sample_o
  );

  function automatic logic [63:0] neg_log2(input logic [31:0] m);
    int          top;
    logic [63:0] y;
    logic [63:0] frac;
    top  = 0;
    frac = 0;
    for (int i = 31; i >= 0; i--) begin
      if (m[i]) begin
        top = i;
        break;
      end
    end
    y = 64'(m) << (31 - top);
    for (int i = 0; i < 28; i++) begin
      y    = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        y    = y >> 1;
      end
    end
    return (64'(32 - top) << 28) - frac;
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] horner(input logic [63:0] x, input bit cos_sel);
    logic [63:0] one;
    logic [63:0] x2;
    logic [63:0] t;
    int unsigned d[6];
    int unsigned n;
    one = 64'd1 << 30;
    x2  = (x * x) >> 30;
    t   = one;
    if (cos_sel) begin
      d = '{132, 90, 56, 30, 12, 2};
      n = 6;
    end else begin
      d = '{110, 72, 42, 20, 6, 1};
      n = 5;
    end
    for (int i = 0; i < n; i++) t = one - ((x2 * t) >> 30) / 64'(d[i]);
    return cos_sel ? t : (x * t) >> 30;
  endfunction

  function automatic logic [31:0] gaussian_of(input uniform_pair_t p);
    logic [31:0] u0;
    logic [63:0] one;
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] e;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] mag;
    logic [1:0]  quad;
    int unsigned sh;
    one  = 64'd1 << 30;
    sh   = 58 - FracBits;
    u0   = (p.radius == 0) ? 32'd1 : p.radius;
    e    = (neg_log2(u0) * 64'(Ln2Q31)) >> 30;
    r    = int_root(e << 28);
    quad = p.angle[31:30];
    q    = 64'(p.angle[29:0]);
    if (quad[0]) q = one - q;
    if (q <= (64'd1 << 29)) begin
      x = (q * 64'(HalfPiQ30) + (64'd1 << 29)) >> 30;
      s = horner(x, 1'b0);
    end else begin
      x = ((one - q) * 64'(HalfPiQ30) + (64'd1 << 29)) >> 30;
      s = horner(x, 1'b1);
    end
    mag = (r * s + (64'd1 << (sh - 1))) >> sh;
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return quad[1] ? 32'd0 - mag[31:0] : mag[31:0];
  endfunction

  task automatic push_pair(input logic [31:0] rad, input logic [31:0] ang);
    pending_q.push_back('{radius: rad, angle: ang});
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    logic [31:0] ang_pts[10];
    rst_ni    = 1'b0;
    drain_req = 1'b0;
    hold_req  = 1'b0;
    stim_done = 1'b0;
    ang_pts = '{32'h0, 32'h2000_0000, 32'h4000_0000, 32'h6000_0000, 32'h8000_0000,
                32'hA000_0000, 32'hC000_0000, 32'hE000_0000, 32'hFFFF_FFFF, 32'h2000_0001};
    foreach (ang_pts[i]) push_pair(32'h0, ang_pts[i]);
    push_pair(32'hFFFF_FFFF, 32'h4000_0000);
    push_pair(32'hFFFF_FFFF, 32'hC000_0000);
    push_pair(32'h0000_0001, 32'h4000_0000);
    push_pair(32'h8000_0000, 32'h4000_0000);
    push_pair(32'hFFFF_FFFE, 32'h1FFF_FFFF);
    push_pair(32'h5555_5555, 32'hAAAA_AAAA);
    push_pair(32'hAAAA_AAAA, 32'h5555_5555);
    push_pair(32'h0000_0002, 32'h0000_0001);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 530; i++) begin
      case ($urandom_range(0, 5))
        0: push_pair($urandom_range(0, 15), $urandom);
        1: push_pair(32'hFFFF_FFFF - $urandom_range(0, 255), $urandom);
        2: push_pair($urandom, {2'($urandom_range(0, 3)), 30'(($urandom_range(0, 1) << 29)
                     + $urandom_range(0, 3) - 1)});
        default: push_pair($urandom, $urandom);
      endcase
      if (i == 150) begin
        hold_req = 1'b1;
        wait (pending_q.size() == 0);
        hold_req = 1'b0;
      end
      if (i == 350) begin
        wait (pending_q.size() == 0);
        drain_req = 1'b1;
        wait (sample_q.size() == 0);
        drain_req = 1'b0;
      end
    end
    wait (pending_q.size() == 0);
    stim_done = 1'b1;
  end

  // Sender: bursts and gaps; pauses fully while draining
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      uniform_radius_i <= '0;
      uniform_angle_i  <= '0;
      burst_left       <= 0;
      gap_left         <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        sample_q.push_back(gaussian_of('{radius: uniform_radius_i, angle: uniform_angle_i}));
        void'(pending_q.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0 || drain_req) begin
          in_valid_i <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else if (pending_q.size() != 0) begin
          uniform_radius_i <= pending_q[0].radius;
          uniform_angle_i  <= pending_q[0].angle;
          in_valid_i       <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= hold_req ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      hold_off    <= 0;
    end else begin
      if (hold_req && hold_off == 0 && stall_mode != 99) begin
        hold_off   <= 300;
        stall_mode <= 99;
        out_stall_i <= 1'b1;
      end else if (hold_off != 0) begin
        hold_off    <= hold_off - 1;
        out_stall_i <= 1'b1;
      end else begin
        if ($urandom_range(0, 63) == 0 && stall_mode != 99) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // Monitor, checker and watchdog
  always @(posedge clk_i) begin
    logic [31:0] exp_sample;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (sample_q.size() == 0) begin
          $error("gaussian_sample: unexpected transfer, actual %0d", gaussian_sample_o);
          n_errors++;
        end else begin
          exp_sample = sample_q.pop_front();
          if (gaussian_sample_o !== exp_sample) begin
            $error("gaussian_sample: expected %0d, actual %0d", $signed(exp_sample),
                   gaussian_sample_o);
            n_errors++;
          end
        end
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= Watchdog) begin
        $display("box_muller_gaussian_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    n_errors    = 0;
    idle_cycles = 0;
    wait (stim_done);
    wait (sample_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (n_errors == 0 && sample_q.size() == 0) begin
      $display("box_muller_gaussian_test: done, clean");
    end else begin
      $display("box_muller_gaussian_test: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
sv/bmg_pkg.sv
sv/bmg_log.sv
sv/bmg_sqrt.sv
sv/bmg_sin.sv
sv/box_muller_gaussian.sv
sim/box_muller_gaussian_test.sv
